@@ rtl/core/cdad_pkg.sv @@
// ----------------------------------------------------------------------------
// cdad_pkg
// Types, constants and month-length helper for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned DAY_W      = 5;
    localparam int unsigned DAYS_FIELD_W = 16;
    localparam int unsigned CENT_W     = 8;

    localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
    localparam logic [YEAR_W-1:0]  CENTURY       = 14'd100;
    localparam logic [YEAR_W-1:0]  LAST_YR_IN_C  = 14'd99;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
    localparam logic [DAY_W-1:0]   LEN_31        = 5'd31;
    localparam logic [DAY_W-1:0]   LEN_30        = 5'd30;
    localparam logic [DAY_W-1:0]   LEN_29        = 5'd29;
    localparam logic [DAY_W-1:0]   LEN_28        = 5'd28;

    typedef struct packed {
        logic [YEAR_W-1:0]       start_year;
        logic [MONTH_W-1:0]      start_month;
        logic [DAY_W-1:0]        start_day;
        logic [DAYS_FIELD_W-1:0] days_to_add;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
        logic               result_is_leap;
        logic               bad_date;
        logic               year_overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } state_t;

    // Zero for month codes outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_30;
            MONTH_FEB:                                  len = leap ? LEN_29 : LEN_28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/calendar_date_add_days_top.sv @@
// ----------------------------------------------------------------------------
// calendar_date_add_days_top
// Gregorian date plus day count, one item at a time, with output register.
// ----------------------------------------------------------------------------
// Adds a non-negative day count to a Gregorian date. Each request item gives
// exactly one response item. Invalid start dates (month not 1..12, day 0 or
// past the month's length, year above 9999) return bad_date with all other
// fields zero. Rolling past December 9999 saturates to 9999-12-31 with
// year_overflow set. Year 0 counts as a leap year. Only the low DAYS_WIDTH
// bits of days_to_add are used (at most the field's 16 bits).
// One shared subtractor does the century split and the month stepping under
// a small sequencer. An item is accepted, its year is split into century and
// year-in-century by repeated subtraction of 100, the date is validated, the
// days are stepped off one month per cycle, and the result is handed off.
// req_stall stays high from acceptance until the result moves into the output
// register, and a new item is taken while a finished result still waits on
// rsp_stall. No reset-time clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days_top
    import cdad_pkg::*;
#(
    parameter int unsigned DAYS_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic core_idle;
    logic core_res_valid;
    rsp_t core_res;
    logic start;
    logic load;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    // take an item only when the sequencer is idle
    assign req_stall = !core_idle;
    assign start     = req_valid && !req_stall;

    // output register frees as soon as its item is taken
    assign load           = core_res_valid && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid_next = load || (rsp_valid_reg && rsp_stall);

    cdad_core #(
        .DAYS_WIDTH (DAYS_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res       (core_res),
        .res_ack   (load)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= core_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/core/cdad_sub_unit.sv @@
// ----------------------------------------------------------------------------
// cdad_sub_unit
// Shared subtract / compare unit: difference and borrow of two operands.
// ----------------------------------------------------------------------------
`default_nettype none

module cdad_sub_unit #(
    parameter int unsigned W = 17
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] diff,
    output logic              borrow
);

    logic [W:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[W-1:0];
    assign borrow = full[W];

endmodule

`default_nettype wire

@@ rtl/core/cdad_core.sv @@
// ----------------------------------------------------------------------------
// cdad_core
// Sequencer: splits the year into century / year-in-century, validates the
// date, then walks month by month through the shared subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cdad_core
    import cdad_pkg::*;
#(
    parameter int unsigned DAYS_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      idle,
    output logic      res_valid,
    output rsp_t      res,
    input  wire logic res_ack
);

    localparam int unsigned ADD_W = (DAYS_WIDTH < DAYS_FIELD_W) ? DAYS_WIDTH : DAYS_FIELD_W;
    localparam int unsigned ACC_W = ADD_W + 1;
    localparam int unsigned ALU_W = (ACC_W > YEAR_W) ? ACC_W : YEAR_W;

    state_t state_reg, state_next;

    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [YEAR_W-1:0]  ywork_reg, ywork_next;
    logic [CENT_W-1:0]  cent_reg,  cent_next;
    logic [ACC_W-1:0]   acc_reg,   acc_next;
    logic               bad_reg,   bad_next;
    logic               ovf_reg,   ovf_next;

    logic [ALU_W-1:0]   alu_a, alu_b, alu_diff;
    logic               alu_borrow;
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic               split_more;
    logic               step_gt;
    logic               date_bad;

    cdad_sub_unit #(
        .W (ALU_W)
    ) u_sub (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    // year = 100*cent + ywork once the split is done
    assign leap = (ywork_reg[1:0] == 2'b00) &&
                  ((ywork_reg != '0) || (cent_reg[1:0] == 2'b00));
    assign mlen = month_len(month_reg, leap);

    assign split_more = !alu_borrow;
    assign step_gt    = !alu_borrow && (alu_diff != '0);
    assign date_bad   = (year_reg > MAX_YEAR) || (mlen == '0) ||
                        (day_reg == '0) || (day_reg > mlen);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (!split_more)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = date_bad ? ST_DONE : ST_STEP;
            end
            ST_STEP:
            begin
                if (!step_gt ||
                    ((month_reg == MONTH_DEC) && (year_reg == MAX_YEAR)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and outputs
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        ywork_next = ywork_reg;
        cent_next  = cent_reg;
        acc_next   = acc_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        alu_a      = ALU_W'(acc_reg);
        alu_b      = ALU_W'(mlen);
        idle       = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    year_next  = req.start_year;
                    month_next = req.start_month;
                    day_next   = req.start_day;
                    ywork_next = req.start_year;
                    cent_next  = '0;
                    acc_next   = ACC_W'(req.days_to_add[ADD_W-1:0]) + ACC_W'(req.start_day);
                    bad_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            ST_SPLIT:
            begin
                alu_a = ALU_W'(ywork_reg);
                alu_b = ALU_W'(CENTURY);
                if (split_more)
                begin
                    ywork_next = alu_diff[YEAR_W-1:0];
                    cent_next  = cent_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                bad_next = date_bad;
            end
            ST_STEP:
            begin
                if (step_gt)
                begin
                    acc_next = alu_diff[ACC_W-1:0];
                    if (month_reg == MONTH_DEC)
                    begin
                        if (year_reg == MAX_YEAR)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + 1'b1;
                            if (ywork_reg == LAST_YR_IN_C)
                            begin
                                ywork_next = '0;
                                cent_next  = cent_reg + 1'b1;
                            end
                            else
                            begin
                                ywork_next = ywork_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (bad_reg)
                begin
                    res.bad_date = 1'b1;
                end
                else if (ovf_reg)
                begin
                    res.result_year   = MAX_YEAR;
                    res.result_month  = MONTH_DEC;
                    res.result_day    = LEN_31;
                    res.year_overflow = 1'b1;
                end
                else
                begin
                    res.result_year    = year_reg;
                    res.result_month   = month_reg;
                    res.result_day     = acc_reg[DAY_W-1:0];
                    res.result_is_leap = leap;
                end
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        ywork_reg <= ywork_next;
        cent_reg  <= cent_next;
        acc_reg   <= acc_next;
        bad_reg   <= bad_next;
        ovf_reg   <= ovf_next;
    end

    a_step_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC))
        else $error("month out of range while stepping");

    a_step_split_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (ywork_reg <= LAST_YR_IN_C))
        else $error("year-in-century not reduced before stepping");

    a_step_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && step_gt) |=> (acc_reg < $past(acc_reg)))
        else $error("day count did not shrink on a month step");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !res_ack) |=> (state_reg == ST_DONE) && $stable(res))
        else $error("finished result dropped before hand-off");

    a_idle_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !res_valid)
        else $error("result shown while idle");

endmodule

`default_nettype wire

@@ tb/sv/tb_calendar_date_add_days_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_date_add_days_top
// Self-checking bench for the Gregorian date adder.
// ----------------------------------------------------------------------------
// A queue of date items (directed corner cases, then random dates) feeds a
// clocked driver. Every accepted item is run through a local date predictor
// and its expected result is queued. A clocked monitor compares each
// accepted result against the oldest expectation, field by field. Both
// sides idle at random in the first two of three phases, and the receiver
// holds off once for a long stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_add_days_top;
    import cdad_pkg::*;

    localparam int unsigned DAYS_W    = 16;    // day count bits the block uses
    localparam int unsigned N_RANDOM  = 250;   // random items after the directed set
    localparam int unsigned NOISE_PCT = 12;    // share of raw, mostly invalid items
    localparam int unsigned HOLD_AT   = 40;    // item count that starts the long hold-off
    localparam int unsigned HOLD_LEN  = 3000;  // start value of the long hold-off counter
    localparam int unsigned DRAIN_CYC = 2400;  // drain window after the last prediction is matched

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t        dates_to_send[$];   // items waiting for the driver
    rsp_t        sums_due[$];        // predicted results, oldest first
    int unsigned n_taken   = 0;      // items accepted by the block
    int unsigned n_errors  = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    calendar_date_add_days_top #(
        .DAYS_WIDTH (DAYS_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Date predictor
    // ------------------------------------------------------------------
    // Gregorian rule: every 4th year, but not centuries unless divisible by 400.
    function automatic bit is_leap(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Zero marks a month code outside 1..12.
    function automatic int unsigned days_in(int unsigned m, bit leap);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = leap ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic rsp_t add_days_to_date(req_t d);
        rsp_t        r;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned mlen;
        bit          leap;
        bit          over;
        r    = '0;
        yr   = 32'(d.start_year);
        mo   = 32'(d.start_month);
        dy   = 32'(d.start_day);
        leap = is_leap(yr);
        mlen = days_in(mo, leap);
        over = 1'b0;
        if (yr > MAX_YEAR || mlen == 0 || dy == 0 || dy > mlen)
        begin
            // invalid start date: flag only, everything else zero
            r.bad_date = 1'b1;
            return r;
        end
        dy = dy + (32'(d.days_to_add) & ((32'd1 << DAYS_W) - 1));
        while (dy > mlen && !over)
        begin
            dy = dy - mlen;
            mo = mo + 1;
            if (mo > MONTH_DEC)
            begin
                mo = MONTH_JAN;
                yr = yr + 1;
                if (yr > MAX_YEAR)
                    over = 1'b1;
                else
                    leap = is_leap(yr);
            end
            mlen = days_in(mo, leap);
        end
        if (over)
        begin
            // saturate to the last representable day
            yr   = MAX_YEAR;
            mo   = MONTH_DEC;
            dy   = 31;
            leap = is_leap(MAX_YEAR);
        end
        r.result_year    = YEAR_W'(yr);
        r.result_month   = MONTH_W'(mo);
        r.result_day     = DAY_W'(dy);
        r.result_is_leap = leap;
        r.year_overflow  = over;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t date_item(int unsigned y, int unsigned m, int unsigned dd,
                                       int unsigned add);
        req_t q;
        q.start_year  = YEAR_W'(y);
        q.start_month = MONTH_W'(m);
        q.start_day   = DAY_W'(dd);
        q.days_to_add = DAYS_FIELD_W'(add);
        return q;
    endfunction

    // Well-formed date; years lean toward century edges and the top of the
    // range, day counts are mostly short so the month stepping stays quick.
    function automatic req_t random_valid_date();
        int unsigned y;
        int unsigned m;
        int unsigned dd;
        int unsigned add;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            y = $urandom_range(99, 1) * 100 - $urandom_range(1);
        else if (pick < 22)
            y = $urandom_range(9999, 9990);
        else
            y = $urandom_range(9999);
        m    = $urandom_range(12, 1);
        dd   = $urandom_range(days_in(m, is_leap(y)), 1);
        pick = $urandom_range(99);
        if (pick < 6)
            add = $urandom_range(65535);
        else if (pick < 16)
            add = $urandom_range(4095);
        else if (pick < 60)
            add = $urandom_range(400);
        else
            add = $urandom_range(40);
        return date_item(y, m, dd, add);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Idle rates by phase: sender-light, then receiver-light, then none
    // ------------------------------------------------------------------
    always_comb
    begin
        if (n_taken < 90)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 53;
        end
        else if (n_taken < 180)
        begin
            send_idle_pct = 53;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ------------------------------------------------------------------
    // Driver: the payload only moves when the current item has gone in
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                sums_due.push_back(add_days_to_date(req));
                n_taken <= n_taken + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (dates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= dates_to_send.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: once, the receiver stalls until the hold-off counter
    // runs down while the driver keeps offering, so the output register and
    // the core fill
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_taken == HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (sums_due.size() == 0)
            begin
                $error("result item with nothing expected: %p", rsp);
                n_errors++;
            end
            else
            begin
                want = sums_due.pop_front();
                check_field("result_year", 32'(want.result_year),
                            32'(rsp.result_year));
                check_field("result_month", 32'(want.result_month),
                            32'(rsp.result_month));
                check_field("result_day", 32'(want.result_day),
                            32'(rsp.result_day));
                check_field("result_is_leap", 32'(want.result_is_leap),
                            32'(rsp.result_is_leap));
                check_field("bad_date", 32'(want.bad_date),
                            32'(rsp.bad_date));
                check_field("year_overflow", 32'(want.year_overflow),
                            32'(rsp.year_overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // leap rules and February edges
        dates_to_send.push_back(date_item(2024, 2, 28, 1));      // into Feb 29
        dates_to_send.push_back(date_item(2023, 2, 28, 1));      // common year, to Mar 1
        dates_to_send.push_back(date_item(1900, 2, 29, 0));      // century, not leap
        dates_to_send.push_back(date_item(2000, 2, 29, 0));      // divisible by 400
        dates_to_send.push_back(date_item(0, 2, 29, 0));         // year zero is leap
        dates_to_send.push_back(date_item(0, 1, 1, 0));          // all-low fields
        dates_to_send.push_back(date_item(0, 1, 1, 65535));      // longest day count
        // invalid start dates
        dates_to_send.push_back(date_item(2021, 0, 10, 5));      // month zero
        dates_to_send.push_back(date_item(2021, 13, 10, 5));
        dates_to_send.push_back(date_item(2021, 15, 31, 65535)); // all-high month and day
        dates_to_send.push_back(date_item(2021, 3, 0, 5));       // day zero
        dates_to_send.push_back(date_item(2021, 4, 31, 0));      // past a 30-day month
        dates_to_send.push_back(date_item(10000, 1, 1, 0));      // year just above range
        dates_to_send.push_back(date_item(16383, 6, 15, 1));     // all-high year
        // roll-overs
        dates_to_send.push_back(date_item(2021, 1, 31, 0));
        dates_to_send.push_back(date_item(2023, 12, 31, 1));     // into a new year
        dates_to_send.push_back(date_item(1999, 12, 31, 60));    // into leap Feb 2000
        dates_to_send.push_back(date_item(2099, 12, 31, 60));    // past common Feb 2100, to Mar 1
        // top of the year range
        dates_to_send.push_back(date_item(9999, 12, 31, 0));
        dates_to_send.push_back(date_item(9999, 12, 31, 1));     // overflow by one day
        dates_to_send.push_back(date_item(9999, 12, 31, 65535));
        dates_to_send.push_back(date_item(9998, 6, 15, 600));    // overflow across a year
        dates_to_send.push_back(date_item(9999, 1, 1, 364));     // lands on the last day

        // random part: mostly well-formed dates, some raw field noise
        repeat (N_RANDOM)
        begin
            if ($urandom_range(99) < NOISE_PCT)
                dates_to_send.push_back(date_item($urandom_range(16383), $urandom_range(15),
                                                  $urandom_range(31), $urandom_range(1023)));
            else
                dates_to_send.push_back(random_valid_date());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // everything accepted, then every prediction matched, then a drain
        // window long enough for any stray result to show up
        while (dates_to_send.size() != 0 || req_valid)
            @(posedge clk);
        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: well past the slowest legal run (every item at full stepping
    // length with both sides idling, plus the long hold-off).
    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/cdad_pkg.sv
rtl/core/cdad_sub_unit.sv
rtl/core/cdad_core.sv
rtl/core/calendar_date_add_days_top.sv
tb/sv/tb_calendar_date_add_days_top.sv
